// File: src/radio_frame_receive_filter_unit_defines.svh
// Assertion macros shared by the radio frame receive filter.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef RADIO_FRAME_RECEIVE_FILTER_UNIT_DEFINES_SVH
`define RADIO_FRAME_RECEIVE_FILTER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFRF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RFRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/rfrf_pkg.sv
`default_nettype none
package rfrf_pkg;

  // Special identifiers carried in frames.
  localparam logic [15:0] BROADCAST_ID        = 16'hFFFF;
  localparam logic [7:0]  BEACON_REQUEST_CODE = 8'h01;

  // Header up to the length byte plus the trailing XOR byte.
  localparam logic [7:0]  MIN_FRAME_LEN = 8'd11;
  localparam logic [7:0]  MAX_COUNT     = 8'hFF;

  // Byte positions within the header.
  localparam logic [7:0] POS_NET_HI  = 8'd1;
  localparam logic [7:0] POS_NET_LO  = 8'd2;
  localparam logic [7:0] POS_SRC_HI  = 8'd3;
  localparam logic [7:0] POS_SRC_LO  = 8'd4;
  localparam logic [7:0] POS_DST_HI  = 8'd5;
  localparam logic [7:0] POS_DST_LO  = 8'd6;
  localparam logic [7:0] POS_PKT_ID  = 8'd7;
  localparam logic [7:0] POS_COMMAND = 8'd8;

  // Verdict codes.
  localparam logic [2:0] VERDICT_ACCEPT     = 3'd0;
  localparam logic [2:0] VERDICT_TOO_SHORT  = 3'd1;
  localparam logic [2:0] VERDICT_BAD_XOR    = 3'd2;
  localparam logic [2:0] VERDICT_NET_MISS   = 3'd3;
  localparam logic [2:0] VERDICT_ADDR_MISS  = 3'd4;

  // Configuration register indexes (word address bits).
  localparam logic [1:0] REG_OWN_NETWORK = 2'd0;
  localparam logic [1:0] REG_OWN_ADDRESS = 2'd1;
  localparam logic [1:0] REG_SLAVE_SEARCH = 2'd2;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Summary of one complete frame, handed from front to back.
  typedef struct packed {
    logic        xor_ok;
    logic [7:0]  len;
    logic [15:0] network;
    logic [15:0] source;
    logic [15:0] dest;
    logic [7:0]  packet_id;
    logic [7:0]  command;
  } frame_sum_t;

  // Queue fill status.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Configuration register contents.
  typedef struct packed {
    logic [15:0] own_network_id;
    logic [15:0] own_address;
    logic        slave_search_open;
  } cfg_t;

endpackage
`default_nettype wire

// File: src/rfrf_front.sv
`default_nettype none
module rfrf_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire logic [7:0]           rx_byte,
  input  wire logic                 last_byte,
  output logic                      push,
  output rfrf_pkg::frame_sum_t      summary
);

  logic [7:0]  xor_accum, xor_accum_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [15:0] rx_network, rx_network_next;
  logic [15:0] rx_source, rx_source_next;
  logic [15:0] rx_dest, rx_dest_next;
  logic [7:0]  rx_packet_id, rx_packet_id_next;
  logic [7:0]  rx_command, rx_command_next;

  // Absorb the current byte into the running frame state.
  always_comb begin
    rx_network_next   = rx_network;
    rx_source_next    = rx_source;
    rx_dest_next      = rx_dest;
    rx_packet_id_next = rx_packet_id;
    rx_command_next   = rx_command;
    unique case (byte_count)
      rfrf_pkg::POS_NET_HI:  rx_network_next[15:8] = rx_byte;
      rfrf_pkg::POS_NET_LO:  rx_network_next[7:0]  = rx_byte;
      rfrf_pkg::POS_SRC_HI:  rx_source_next[15:8]  = rx_byte;
      rfrf_pkg::POS_SRC_LO:  rx_source_next[7:0]   = rx_byte;
      rfrf_pkg::POS_DST_HI:  rx_dest_next[15:8]    = rx_byte;
      rfrf_pkg::POS_DST_LO:  rx_dest_next[7:0]     = rx_byte;
      rfrf_pkg::POS_PKT_ID:  rx_packet_id_next     = rx_byte;
      rfrf_pkg::POS_COMMAND: rx_command_next       = rx_byte;
      default: ;
    endcase
    xor_accum_next  = xor_accum ^ rx_byte;
    byte_count_next = (byte_count == rfrf_pkg::MAX_COUNT) ? byte_count
                                                          : byte_count + 8'd1;
  end

  // A flagged byte closes the frame and hands its summary to the queue.
  assign push              = accept && last_byte;
  assign summary.xor_ok    = (xor_accum_next == 8'd0);
  assign summary.len       = byte_count_next;
  assign summary.network   = rx_network_next;
  assign summary.source    = rx_source_next;
  assign summary.dest      = rx_dest_next;
  assign summary.packet_id = rx_packet_id_next;
  assign summary.command   = rx_command_next;

  // Frame state: cleared on reset and after each completed frame.
  always_ff @(posedge clk) begin
    if (rst || push) begin
      xor_accum    <= '0;
      byte_count   <= '0;
      rx_network   <= '0;
      rx_source    <= '0;
      rx_dest      <= '0;
      rx_packet_id <= '0;
      rx_command   <= '0;
    end else if (accept) begin
      xor_accum    <= xor_accum_next;
      byte_count   <= byte_count_next;
      rx_network   <= rx_network_next;
      rx_source    <= rx_source_next;
      rx_dest      <= rx_dest_next;
      rx_packet_id <= rx_packet_id_next;
      rx_command   <= rx_command_next;
    end
  end

endmodule
`default_nettype wire

// File: src/rfrf_queue.sv
`default_nettype none
module rfrf_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire rfrf_pkg::frame_sum_t push_data,
  input  wire logic                 pop,
  output rfrf_pkg::frame_sum_t      head,
  output rfrf_pkg::q_status_t       status
);

  rfrf_pkg::frame_sum_t             entries [rfrf_pkg::QUEUE_DEPTH];
  logic [rfrf_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [rfrf_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [rfrf_pkg::QUEUE_CNT_W-1:0] count;
  logic                             do_push;
  logic                             do_pop;

  assign status.full  = (count == rfrf_pkg::QUEUE_CNT_W'(rfrf_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == rfrf_pkg::QUEUE_PTR_W'(rfrf_pkg::QUEUE_DEPTH - 1))
                  ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == rfrf_pkg::QUEUE_PTR_W'(rfrf_pkg::QUEUE_DEPTH - 1))
                  ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: src/rfrf_back.sv
`default_nettype none
module rfrf_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rfrf_pkg::cfg_t       cfg,
  input  wire rfrf_pkg::frame_sum_t head,
  input  wire logic                 head_valid,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [2:0]                verdict,
  output logic [7:0]                command,
  output logic [15:0]               source_addr,
  output logic [15:0]               dest_addr,
  output logic [7:0]                packet_id,
  output logic [7:0]                frame_len
);

  logic       net_ok;
  logic       skip_dest;
  logic       dest_ok;
  logic [2:0] verdict_next;

  // Checks on the frame at the head of the queue; the first failure decides.
  always_comb begin
    net_ok = (head.network == cfg.own_network_id) ||
             (head.network == rfrf_pkg::BROADCAST_ID) ||
             (cfg.own_network_id == rfrf_pkg::BROADCAST_ID);
    skip_dest = (head.command == rfrf_pkg::BEACON_REQUEST_CODE) && cfg.slave_search_open;
    dest_ok = skip_dest || (head.dest == cfg.own_address) ||
              (head.dest == rfrf_pkg::BROADCAST_ID);
    priority if (head.len < rfrf_pkg::MIN_FRAME_LEN) begin
      verdict_next = rfrf_pkg::VERDICT_TOO_SHORT;
    end else if (!head.xor_ok) begin
      verdict_next = rfrf_pkg::VERDICT_BAD_XOR;
    end else if (!net_ok) begin
      verdict_next = rfrf_pkg::VERDICT_NET_MISS;
    end else if (!dest_ok) begin
      verdict_next = rfrf_pkg::VERDICT_ADDR_MISS;
    end else begin
      verdict_next = rfrf_pkg::VERDICT_ACCEPT;
    end
  end

  // Take the next frame whenever the output register is empty or being drained.
  assign pop = head_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (pop) begin
      verdict     <= verdict_next;
      command     <= head.command;
      source_addr <= head.source;
      dest_addr   <= head.dest;
      packet_id   <= head.packet_id;
      frame_len   <= head.len;
    end
  end

endmodule
`default_nettype wire

// File: src/radio_frame_receive_filter_unit.sv
// Receive filter for radio frames. Bytes enter one per cycle on the input
// channel; the input stalls only when two finished frames are already waiting
// behind a stalled output, which is the depth of the frame queue between the
// byte-absorbing front part and the verdict stage. Bytes without the last flag
// give no result. The byte flagged as last yields one result, registered first in the
// frame queue and then in the output register: a verdict of
// accept, too short, bad XOR, network mismatch or address mismatch, together
// with the header fields and the saturating frame length. Configuration is
// written through the APB port at byte addresses 0, 4 and 8, by the user only
// while no frame is in flight; the block itself does not enforce this.
`default_nettype none
`include "radio_frame_receive_filter_unit_defines.svh"
module radio_frame_receive_filter_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // Byte input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        last_byte,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       verdict,
  output logic [7:0]       command,
  output logic [15:0]      source_addr,
  output logic [15:0]      dest_addr,
  output logic [7:0]       packet_id,
  output logic [7:0]       frame_len,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  rfrf_pkg::cfg_t       cfg;
  rfrf_pkg::frame_sum_t summary;
  rfrf_pkg::frame_sum_t head;
  rfrf_pkg::q_status_t  q_status;
  logic                 accept;
  logic                 push;
  logic                 pop;
  logic                 cfg_write;
  logic [1:0]           reg_index;

  // Configuration registers.
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (reg_index)
        rfrf_pkg::REG_OWN_NETWORK:  cfg.own_network_id    <= pwdata[15:0];
        rfrf_pkg::REG_OWN_ADDRESS:  cfg.own_address       <= pwdata[15:0];
        rfrf_pkg::REG_SLAVE_SEARCH: cfg.slave_search_open <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      rfrf_pkg::REG_OWN_NETWORK:  prdata = {16'd0, cfg.own_network_id};
      rfrf_pkg::REG_OWN_ADDRESS:  prdata = {16'd0, cfg.own_address};
      rfrf_pkg::REG_SLAVE_SEARCH: prdata = {31'd0, cfg.slave_search_open};
      default:                    prdata = '0;
    endcase
  end

  // A request is refused only while the frame queue is full.
  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  rfrf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .last_byte (last_byte),
    .push      (push),
    .summary   (summary)
  );

  rfrf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (summary),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  rfrf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .head_valid  (!q_status.empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .verdict     (verdict),
    .command     (command),
    .source_addr (source_addr),
    .dest_addr   (dest_addr),
    .packet_id   (packet_id),
    .frame_len   (frame_len)
  );

  // A closed frame must always find room in the queue.
  `RFRF_ASSERT_SAME(a_no_overflow, push, !q_status.full, "frame pushed into a full queue")
  // A closed frame is waiting in the queue in the following cycle.
  `RFRF_ASSERT_NEXT(a_frame_queued, push, !q_status.empty, "closed frame not queued")
  // Short frames are always reported as too short.
  `RFRF_ASSERT_SAME(a_short_verdict, out_valid && (frame_len < rfrf_pkg::MIN_FRAME_LEN),
                    verdict == rfrf_pkg::VERDICT_TOO_SHORT, "short frame not flagged")
  // The output register is loaded only from a non-empty queue.
  `RFRF_ASSERT_SAME(a_pop_nonempty, pop, !q_status.empty, "pop from an empty queue")

endmodule
`default_nettype wire

// File: verif/tb_radio_frame_receive_filter_unit.sv
`default_nettype none
module tb_radio_frame_receive_filter_unit;

  // One verdict with the header fields that travel with it.
  typedef struct packed {
    logic [2:0]  verdict;
    logic [7:0]  command;
    logic [15:0] source;
    logic [15:0] dest;
    logic [7:0]  packet_id;
    logic [7:0]  len;
  } frame_verdict_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  verdict;
  logic [7:0]  command;
  logic [15:0] source_addr;
  logic [15:0] dest_addr;
  logic [7:0]  packet_id;
  logic [7:0]  frame_len;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Filter settings as this node holds them.
  logic [15:0] node_network;
  logic [15:0] node_address;
  logic        node_searching;

  // Frame being assembled, mirrored byte by byte.
  logic [7:0]  frame_xor;
  logic [7:0]  frame_count;
  logic [15:0] frame_network;
  logic [15:0] frame_source;
  logic [15:0] frame_dest;
  logic [7:0]  frame_packet;
  logic [7:0]  frame_command;

  frame_verdict_t awaited_verdicts[$];
  int unsigned    mismatches;
  int unsigned    send_idle_pct;
  int unsigned    recv_stall_pct;
  int unsigned    bytes_sent;

  radio_frame_receive_filter_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall), .verdict(verdict), .command(command),
    .source_addr(source_addr), .dest_addr(dest_addr), .packet_id(packet_id),
    .frame_len(frame_len),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Absorb one accepted byte; on the last byte work out the verdict it should give.
  function automatic void absorb_byte(input logic [7:0] b, input logic fin);
    frame_verdict_t v;
    logic           net_ok;
    logic           dest_ok;
    case (frame_count)
      rfrf_pkg::POS_NET_HI:  frame_network[15:8] = b;
      rfrf_pkg::POS_NET_LO:  frame_network[7:0]  = b;
      rfrf_pkg::POS_SRC_HI:  frame_source[15:8]  = b;
      rfrf_pkg::POS_SRC_LO:  frame_source[7:0]   = b;
      rfrf_pkg::POS_DST_HI:  frame_dest[15:8]    = b;
      rfrf_pkg::POS_DST_LO:  frame_dest[7:0]     = b;
      rfrf_pkg::POS_PKT_ID:  frame_packet        = b;
      rfrf_pkg::POS_COMMAND: frame_command       = b;
      default: ;
    endcase
    frame_xor = frame_xor ^ b;
    if (frame_count != rfrf_pkg::MAX_COUNT) frame_count = frame_count + 8'd1;
    if (fin) begin
      net_ok = (frame_network == node_network) ||
               (frame_network == rfrf_pkg::BROADCAST_ID) ||
               (node_network == rfrf_pkg::BROADCAST_ID);
      dest_ok = (frame_command == rfrf_pkg::BEACON_REQUEST_CODE && node_searching) ||
                (frame_dest == node_address) || (frame_dest == rfrf_pkg::BROADCAST_ID);
      if (frame_count < rfrf_pkg::MIN_FRAME_LEN) v.verdict = rfrf_pkg::VERDICT_TOO_SHORT;
      else if (frame_xor != 8'd0)      v.verdict = rfrf_pkg::VERDICT_BAD_XOR;
      else if (!net_ok)                v.verdict = rfrf_pkg::VERDICT_NET_MISS;
      else if (!dest_ok)               v.verdict = rfrf_pkg::VERDICT_ADDR_MISS;
      else                             v.verdict = rfrf_pkg::VERDICT_ACCEPT;
      v.command   = frame_command;
      v.source    = frame_source;
      v.dest      = frame_dest;
      v.packet_id = frame_packet;
      v.len       = frame_count;
      awaited_verdicts.push_back(v);
      frame_xor     = '0;
      frame_count   = '0;
      frame_network = '0;
      frame_source  = '0;
      frame_dest    = '0;
      frame_packet  = '0;
      frame_command = '0;
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare every result taken from the block with the oldest awaited verdict.
  always @(posedge clk) begin
    frame_verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_verdicts.size() == 0) begin
        $error("verdict: expected none, got %0h", verdict);
        mismatches++;
      end else begin
        want = awaited_verdicts.pop_front();
        check_field("verdict", 16'(want.verdict), 16'(verdict));
        check_field("command", 16'(want.command), 16'(command));
        check_field("source_addr", want.source, source_addr);
        check_field("dest_addr", want.dest, dest_addr);
        check_field("packet_id", 16'(want.packet_id), 16'(packet_id));
        check_field("frame_len", 16'(want.len), 16'(frame_len));
      end
    end
  end

  // The receiver stalls at random at the current rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Offer one byte, with random idle cycles first, and wait until it is accepted.
  task automatic push_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    rx_byte   <= b;
    last_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_byte(b, fin);
    bytes_sent++;
  endtask

  // Let every awaited verdict arrive and the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (awaited_verdicts.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Write one register through the configuration port once the block is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      rfrf_pkg::REG_OWN_NETWORK:  node_network   = val;
      rfrf_pkg::REG_OWN_ADDRESS:  node_address   = val;
      rfrf_pkg::REG_SLAVE_SEARCH: node_searching = val[0];
      default: ;
    endcase
  endtask

  // A frame of random bytes, flagged as last on its final byte.
  task automatic send_raw(input int n);
    for (int i = 0; i < n; i++) push_byte(8'($urandom), i == n - 1);
  endtask

  // A well-formed frame; the check byte is spoilt when corrupt is set.
  task automatic send_frame(input logic [15:0] net, input logic [15:0] src,
                            input logic [15:0] dst, input logic [7:0] pkt,
                            input logic [7:0] cmd, input int pay_len, input bit corrupt);
    logic [7:0] fb[$];
    logic [7:0] x;
    fb = {};
    fb.push_back(8'($urandom));
    fb.push_back(net[15:8]);
    fb.push_back(net[7:0]);
    fb.push_back(src[15:8]);
    fb.push_back(src[7:0]);
    fb.push_back(dst[15:8]);
    fb.push_back(dst[7:0]);
    fb.push_back(pkt);
    fb.push_back(cmd);
    fb.push_back(8'(pay_len));
    for (int i = 0; i < pay_len; i++) fb.push_back(8'($urandom));
    x = '0;
    foreach (fb[i]) x = x ^ fb[i];
    if (corrupt) x = x ^ 8'($urandom_range(1, 255));
    fb.push_back(x);
    foreach (fb[i]) push_byte(fb[i], i == fb.size() - 1);
  endtask

  function automatic logic [15:0] pick_id(input logic [15:0] own);
    case ($urandom_range(2))
      0:       return own;
      1:       return rfrf_pkg::BROADCAST_ID;
      default: return 16'($urandom);
    endcase
  endfunction

  // Frame lengths: a lone byte, one short of the minimum, exactly minimal, and
  // a frame long enough for the counter to saturate.
  task automatic test_frame_length();
    send_raw(1);
    send_raw(10);
    send_frame(16'h0, 16'h1357, 16'h0, 8'h42, 8'h05, 0, 0);
    send_frame(16'h0, 16'h2468, 16'h0, 8'h43, 8'h06, 250, 0);
  endtask

  task automatic test_checksum();
    send_frame(16'h0, 16'hace1, 16'h0, 8'h10, 8'h20, 3, 1);
    send_raw(14);
  endtask

  // Network match, mismatch and the broadcast identifier on either side.
  task automatic test_network();
    write_reg(rfrf_pkg::REG_OWN_NETWORK, 16'h1234);
    write_reg(rfrf_pkg::REG_OWN_ADDRESS, 16'h5678);
    send_frame(16'h1234, 16'h0001, 16'h5678, 8'h01, 8'h02, 2, 0);
    send_frame(16'h4321, 16'h0002, 16'h5678, 8'h02, 8'h02, 2, 0);
    send_frame(rfrf_pkg::BROADCAST_ID, 16'h0003, 16'h5678, 8'h03, 8'h02, 1, 0);
    write_reg(rfrf_pkg::REG_OWN_NETWORK, rfrf_pkg::BROADCAST_ID);
    send_frame(16'h4321, 16'h0004, 16'h5678, 8'h04, 8'h02, 1, 0);
  endtask

  // Destination mismatch, broadcast, and the beacon request relaxation.
  task automatic test_destination();
    send_frame(16'h0bad, 16'h0005, 16'h0001, 8'h05, 8'h03, 0, 0);
    send_frame(16'h0bad, 16'h0006, rfrf_pkg::BROADCAST_ID, 8'h06, 8'h03, 0, 0);
    send_frame(16'h0bad, 16'h0007, 16'h7777, 8'h07, rfrf_pkg::BEACON_REQUEST_CODE, 0, 0);
    write_reg(rfrf_pkg::REG_SLAVE_SEARCH, 16'h1);
    send_frame(16'h0bad, 16'h0008, 16'h7777, 8'h08, rfrf_pkg::BEACON_REQUEST_CODE, 0, 0);
    send_frame(16'h0bad, 16'h0009, 16'h7777, 8'h09, 8'h02, 0, 0);
    write_reg(rfrf_pkg::REG_SLAVE_SEARCH, 16'h0);
  endtask

  // Header fields at their extremes.
  task automatic test_field_extremes();
    write_reg(rfrf_pkg::REG_OWN_NETWORK, 16'h0);
    write_reg(rfrf_pkg::REG_OWN_ADDRESS, 16'h0);
    send_frame(16'h0, 16'h0, 16'h0, 8'h00, 8'h00, 0, 0);
    write_reg(rfrf_pkg::REG_OWN_ADDRESS, rfrf_pkg::BROADCAST_ID);
    send_frame(rfrf_pkg::BROADCAST_ID, rfrf_pkg::BROADCAST_ID, rfrf_pkg::BROADCAST_ID,
               8'hff, 8'hff, 5, 0);
  endtask

  // Random traffic under fresh settings: mostly well-formed frames, the rest
  // spoilt check bytes, short frames and plain noise.
  task automatic test_random_traffic(input int unsigned snd, input int unsigned rcv,
                                     input int unsigned budget);
    int unsigned pick;
    logic [15:0] net;
    logic [15:0] dst;
    logic [7:0]  cmd;
    write_reg(rfrf_pkg::REG_OWN_NETWORK, pick_id(16'h0));
    write_reg(rfrf_pkg::REG_OWN_ADDRESS, pick_id(16'h0));
    write_reg(rfrf_pkg::REG_SLAVE_SEARCH, 16'($urandom_range(1)));
    send_idle_pct  = snd;
    recv_stall_pct = rcv;
    bytes_sent = 0;
    while (bytes_sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        send_raw($urandom_range(1, 10));
      end else if (pick < 25) begin
        send_raw($urandom_range(11, 20));
      end else begin
        net = pick_id(node_network);
        dst = pick_id(node_address);
        cmd = ($urandom_range(2) == 0) ? rfrf_pkg::BEACON_REQUEST_CODE : 8'($urandom);
        send_frame(net, 16'($urandom), dst, 8'($urandom), cmd, $urandom_range(0, 8),
                   pick < 35);
      end
    end
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    rx_byte   <= 8'h0;
    last_byte <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= 4'h0;
    pwdata    <= 32'h0;
    node_network   = '0;
    node_address   = '0;
    node_searching = 1'b0;
    frame_xor      = '0;
    frame_count    = '0;
    frame_network  = '0;
    frame_source   = '0;
    frame_dest     = '0;
    frame_packet   = '0;
    frame_command  = '0;
    mismatches     = 0;
    send_idle_pct  = 20;
    recv_stall_pct = 30;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_frame_length();
    test_checksum();
    test_network();
    test_destination();
    test_field_extremes();
    test_random_traffic(25, 84, 65);
    test_random_traffic(84, 25, 65);
    test_random_traffic(0, 0, 65);

    drain();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Guard against a block that stops delivering.
  initial begin
    #(20 * 400000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
`default_nettype wire
